// File: hw/rtl/fcpr_pkg.sv
// shared constants, types and helper functions of the framed command packet receiver
package fcpr_pkg;

   localparam int FRAME_BYTES = 16;
   localparam int STORE_DEPTH = FRAME_BYTES - 2;
   localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
   localparam int POS_W       = $clog2(FRAME_BYTES);
   localparam int UNIT_W      = 25;

   localparam logic [POS_W-1:0] POS_HUNT = '0;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

   localparam logic [7:0] START_BYTE  = 8'hFF;
   localparam logic [7:0] END_BYTE    = 8'hFE;
   localparam logic [7:0] VOLUME_MARK = 8'hF0;
   localparam logic [7:0] AUDIO_STOP  = 8'h00;
   localparam logic [7:0] TEMP_LOW    = 8'd10;
   localparam logic [7:0] TEMP_HIGH   = 8'd60;
   localparam logic [7:0] SUSTAIN_MAX = 8'd60;
   localparam logic [7:0] MODE_MAX    = 8'd2;
   localparam logic [7:0] MODE_AUDIO  = 8'd2;
   localparam logic [7:0] FLAG_ON     = 8'd1;
   localparam logic [7:0] OWN_ID_RESET = 8'd1;

   localparam logic [7:0] DROP_END   = 8'd0;
   localparam logic [7:0] DROP_ID    = 8'd1;
   localparam logic [7:0] DROP_MODE  = 8'd2;
   localparam logic [7:0] DROP_TEMP1 = 8'd3;
   localparam logic [7:0] DROP_TEMP2 = 8'd4;
   localparam logic [7:0] DROP_SUST1 = 8'd5;
   localparam logic [7:0] DROP_SUST2 = 8'd6;

   // frame store slots, byte n of the frame sits at slot n-1
   localparam int SLOT_ID    = 0;
   localparam int SLOT_MODE  = 1;
   localparam int SLOT_UNIT1 = 2;
   localparam int SLOT_UNIT2 = 6;
   localparam int SLOT_VOL   = 10;
   localparam int SLOT_LOOP  = 11;
   localparam int SLOT_PRE   = 12;
   localparam int SLOT_SND   = 13;

   typedef enum logic [1:0] {
      KIND_COMMAND = 2'd0,
      KIND_AUDIO   = 2'd1,
      KIND_DROP    = 2'd2
   } kind_type;

   typedef logic [STORE_DEPTH-1:0][7:0] frame_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         value;
      logic               last;
      logic [1:0]         mode;
      logic [UNIT_W-1:0]  unit_one;
      logic [UNIT_W-1:0]  unit_two;
      logic               loop_on;
      logic [7:0]         preset;
      logic [7:0]         sound;
   } result_type;

   typedef struct packed {
      logic       hunting;
      logic       last_byte;
   } pos_state_type;

   function automatic logic temp_bad(input logic [7:0] temp, input logic [7:0] fan,
                                     input logic [7:0] fan_only);
      return (fan_only != FLAG_ON) && (fan != 8'd0) && (temp != 8'd0) &&
             ((temp < TEMP_LOW) || (temp > TEMP_HIGH));
   endfunction

   function automatic logic [UNIT_W-1:0] pack_unit(input logic [7:0] temp,
                                                   input logic [7:0] sust,
                                                   input logic [7:0] fan,
                                                   input logic [7:0] fan_only);
      return {fan_only == FLAG_ON, fan, sust, temp};
   endfunction

   function automatic result_type simple_result(input kind_type kind, input logic [7:0] value,
                                                input logic last);
      result_type r;
      r = '0;
      r.kind  = kind;
      r.value = value;
      r.last  = last;
      return r;
   endfunction

endpackage

// File: hw/rtl/fcpr_collect.sv
// byte position counter and frame store
module fcpr_collect (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   output fcpr_pkg::pos_state_type pos_state,
   output fcpr_pkg::frame_type frame
);
   import fcpr_pkg::*;

   logic [POS_W-1:0]       pos_ff, pos_in;
   frame_type              store_ff;
   logic [STORE_IDX_W-1:0] wr_idx;
   logic                   wr_en;

   assign pos_state.hunting   = (pos_ff == POS_HUNT);
   assign pos_state.last_byte = (pos_ff == POS_LAST);
   assign wr_idx = STORE_IDX_W'(pos_ff - POS_W'(1));
   assign wr_en  = accept && !pos_state.hunting && !pos_state.last_byte;
   assign frame  = store_ff;

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (pos_state.hunting) begin
            if (rx_byte == START_BYTE) pos_in = POS_W'(1);
         end else if (pos_state.last_byte) begin
            pos_in = POS_HUNT;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (wr_en && (wr_idx == STORE_IDX_W'(i))) store_ff[i] <= rx_byte;
      end
   end

   a_hunt_ignores: assert property (@(posedge clock) disable iff (reset)
      accept && pos_state.hunting && (rx_byte != START_BYTE) |=> pos_ff == POS_HUNT)
      else $error("non-start byte left hunt");
   a_frame_wraps: assert property (@(posedge clock) disable iff (reset)
      accept && pos_state.last_byte |=> pos_ff == POS_HUNT)
      else $error("frame end did not return to hunt");
   a_start_enters: assert property (@(posedge clock) disable iff (reset)
      accept && pos_state.hunting && (rx_byte == START_BYTE) |=> pos_ff == POS_W'(1))
      else $error("start byte not taken");

endmodule

// File: hw/rtl/fcpr_check.sv
// frame validation and command or audio decode
module fcpr_check (
   input  fcpr_pkg::frame_type  frame,
   input  logic [7:0]           end_byte,
   input  logic [7:0]           own_id,
   output logic                 two_results,
   output fcpr_pkg::result_type res0,
   output fcpr_pkg::result_type res1
);
   import fcpr_pkg::*;

   logic [7:0] id, md, t1, s1, f1, o1, t2, s2, f2, o2, vol, lp, pre, snd;
   logic       loop;
   logic       audio_only;
   logic [7:0] track_code;

   assign id  = frame[SLOT_ID];
   assign md  = frame[SLOT_MODE];
   assign t1  = frame[SLOT_UNIT1];
   assign s1  = frame[SLOT_UNIT1 + 1];
   assign f1  = frame[SLOT_UNIT1 + 2];
   assign o1  = frame[SLOT_UNIT1 + 3];
   assign t2  = frame[SLOT_UNIT2];
   assign s2  = frame[SLOT_UNIT2 + 1];
   assign f2  = frame[SLOT_UNIT2 + 2];
   assign o2  = frame[SLOT_UNIT2 + 3];
   assign vol = frame[SLOT_VOL];
   assign lp  = frame[SLOT_LOOP];
   assign pre = frame[SLOT_PRE];
   assign snd = frame[SLOT_SND];

   assign loop = (lp == FLAG_ON);
   assign audio_only = (md == MODE_AUDIO) && (pre == 8'd0) && (t1 == 8'd0) && (s1 == 8'd0) &&
                       (f1 == 8'd0) && (t2 == 8'd0) && (s2 == 8'd0) && (f2 == 8'd0);
   // (snd - 1) * 2 + 1 + loop, wrapping at 8 bits
   assign track_code = {snd[6:0], 1'b0} - 8'd1 + {7'd0, loop};

   always_comb begin
      two_results = 1'b0;
      res1 = simple_result(KIND_AUDIO, vol, 1'b1);
      if (end_byte != END_BYTE) begin
         res0 = simple_result(KIND_DROP, DROP_END, 1'b1);
      end else if (id != own_id) begin
         res0 = simple_result(KIND_DROP, DROP_ID, 1'b1);
      end else if (md > MODE_MAX) begin
         res0 = simple_result(KIND_DROP, DROP_MODE, 1'b1);
      end else if (temp_bad(t1, f1, o1)) begin
         res0 = simple_result(KIND_DROP, DROP_TEMP1, 1'b1);
      end else if (temp_bad(t2, f2, o2)) begin
         res0 = simple_result(KIND_DROP, DROP_TEMP2, 1'b1);
      end else if (s1 > SUSTAIN_MAX) begin
         res0 = simple_result(KIND_DROP, DROP_SUST1, 1'b1);
      end else if (s2 > SUSTAIN_MAX) begin
         res0 = simple_result(KIND_DROP, DROP_SUST2, 1'b1);
      end else if (audio_only) begin
         if (vol != 8'd0) begin
            res0 = simple_result(KIND_AUDIO, VOLUME_MARK, 1'b0);
            two_results = 1'b1;
         end else if (snd == 8'd0) begin
            res0 = simple_result(KIND_AUDIO, AUDIO_STOP, 1'b1);
         end else begin
            res0 = simple_result(KIND_AUDIO, track_code, 1'b1);
         end
      end else begin
         res0 = simple_result(KIND_COMMAND, 8'd0, 1'b1);
         res0.mode     = md[1:0];
         res0.unit_one = pack_unit(t1, s1, f1, o1);
         res0.unit_two = pack_unit(t2, s2, f2, o2);
         res0.loop_on  = loop;
         res0.preset   = pre;
         res0.sound    = snd;
      end
   end

endmodule

// File: hw/rtl/fcpr_queue.sv
// two-entry result register feeding the response channel
module fcpr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic                 push_two,
   input  fcpr_pkg::result_type push_res0,
   input  fcpr_pkg::result_type push_res1,
   input  logic                 pop,
   output logic                 room,
   output logic                 head_valid,
   output fcpr_pkg::result_type head
);
   import fcpr_pkg::*;

   logic [1:0] count_ff, count_in;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;

   assign head_valid = (count_ff != 2'd0);
   assign head       = slot0_ff;
   // a push needs both slots free once this cycle's pop is done
   assign room = (count_ff == 2'd0) || ((count_ff == 2'd1) && pop);

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push) begin
         slot0_in = push_res0;
         slot1_in = push_res1;
         count_in = push_two ? 2'd2 : 2'd1;
      end else if (pop && head_valid) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result count overflow");
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> room)
      else $error("push without free slots");
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      push && push_two |=> count_ff == 2'd2)
      else $error("two-result push lost an entry");

endmodule

// File: hw/rtl/framed_command_packet_receiver.sv
// top level of the framed command packet receiver
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    req_rx_byte
//  rsp      out        rsp_valid/rsp_ready    rsp_event_kind ... rsp_sound_track
//  csr      in         csr_wr_en              csr_wr_data (own id)
//
// one byte per cycle while req_ready is high; the frame end byte is checked in the cycle it is taken
// and its one or two results are visible in the next cycle
// bytes other than the frame end byte are always accepted
// the frame end byte waits only while results of the previous frame remain
// reset clears the position counter, the result queue and sets own id to one
module framed_command_packet_receiver (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_event_kind,
   output logic [7:0]                  rsp_event_value,
   output logic                        rsp_last_of_run,
   output logic [1:0]                  rsp_mode,
   output logic [fcpr_pkg::UNIT_W-1:0] rsp_unit_one,
   output logic [fcpr_pkg::UNIT_W-1:0] rsp_unit_two,
   output logic                        rsp_loop_on,
   output logic [7:0]                  rsp_preset_number,
   output logic [7:0]                  rsp_sound_track,
   input  logic                        csr_wr_en,
   input  logic [7:0]                  csr_wr_data
);
   import fcpr_pkg::*;

   logic [7:0]    own_id_ff;
   pos_state_type pos_state;
   frame_type     frame;
   logic          accept;
   logic          push;
   logic          two_results;
   logic          room;
   result_type    res0, res1, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= OWN_ID_RESET;
      end else if (csr_wr_en) begin
         own_id_ff <= csr_wr_data;
      end
   end

   assign req_ready = !pos_state.last_byte || room;
   assign accept    = req_valid && req_ready;
   assign push      = accept && pos_state.last_byte;

   fcpr_collect u_collect (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .pos_state (pos_state),
      .frame     (frame)
   );

   fcpr_check u_check (
      .frame       (frame),
      .end_byte    (req_rx_byte),
      .own_id      (own_id_ff),
      .two_results (two_results),
      .res0        (res0),
      .res1        (res1)
   );

   fcpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_two   (two_results),
      .push_res0  (res0),
      .push_res1  (res1),
      .pop        (rsp_ready),
      .room       (room),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_event_kind    = head.kind;
   assign rsp_event_value   = head.value;
   assign rsp_last_of_run   = head.last;
   assign rsp_mode          = head.mode;
   assign rsp_unit_one      = head.unit_one;
   assign rsp_unit_two      = head.unit_two;
   assign rsp_loop_on       = head.loop_on;
   assign rsp_preset_number = head.preset;
   assign rsp_sound_track   = head.sound;

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_valid)
      else $error("frame end produced no transaction");
   a_no_result_midframe: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !push |=> !rsp_valid)
      else $error("transaction appeared without a frame end");
   a_mid_bytes_flow: assert property (@(posedge clock) disable iff (reset)
      !pos_state.last_byte |-> req_ready)
      else $error("stalled on a mid-frame byte");

endmodule

// File: tb/tb_framed_command_packet_receiver.sv
// testbench of the framed command packet receiver: directed and random frames against a predictor
`timescale 1ns / 1ps
module tb_framed_command_packet_receiver;
   import fcpr_pkg::*;

   localparam int AT_ID            = SLOT_ID + 1;
   localparam int AT_MODE          = SLOT_MODE + 1;
   localparam int AT_UNIT1         = SLOT_UNIT1 + 1;
   localparam int AT_UNIT2         = SLOT_UNIT2 + 1;
   localparam int AT_VOL           = SLOT_VOL + 1;
   localparam int AT_LOOP          = SLOT_LOOP + 1;
   localparam int AT_PRE           = SLOT_PRE + 1;
   localparam int AT_SND           = SLOT_SND + 1;
   localparam int AT_END           = FRAME_BYTES - 1;
   localparam int OFS_TEMP         = 0;
   localparam int OFS_SUST         = 1;
   localparam int OFS_FAN          = 2;
   localparam int OFS_FAN_ONLY     = 3;
   localparam int FRAMES_PER_PHASE = 13;
   localparam int MAX_PRINTED      = 200;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_image_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [7:0]          req_rx_byte;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [1:0]          rsp_event_kind;
   logic [7:0]          rsp_event_value;
   logic                rsp_last_of_run;
   logic [1:0]          rsp_mode;
   logic [UNIT_W-1:0]   rsp_unit_one;
   logic [UNIT_W-1:0]   rsp_unit_two;
   logic                rsp_loop_on;
   logic [7:0]          rsp_preset_number;
   logic [7:0]          rsp_sound_track;
   logic                csr_wr_en;
   logic [7:0]          csr_wr_data;

   logic [POS_W-1:0]    frame_pos;
   logic [7:0]          rx_store [STORE_DEPTH];
   logic [7:0]          own_id_model;
   result_type          pending_events [$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatches         = 0;
   int bytes_sent         = 0;
   int results_seen       = 0;
   int commands_seen      = 0;
   int audio_seen         = 0;
   int drops_seen         = 0;

   framed_command_packet_receiver dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_event_value   (rsp_event_value),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_mode          (rsp_mode),
      .rsp_unit_one      (rsp_unit_one),
      .rsp_unit_two      (rsp_unit_two),
      .rsp_loop_on       (rsp_loop_on),
      .rsp_preset_number (rsp_preset_number),
      .rsp_sound_track   (rsp_sound_track),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("ERROR %0t: %s", $time, msg);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] exp);
      if (got !== exp) begin
         report_mismatch($sformatf("%s got %0h expected %0h at transaction %0d",
                                   name, got, exp, results_seen));
      end
   endtask

   // --- predictor ---

   function automatic logic heater_rejected(input logic [7:0] temp, input logic [7:0] fan,
                                            input logic [7:0] fan_only);
      if (fan_only == FLAG_ON || fan == 8'd0 || temp == 8'd0) begin
         return 1'b0;
      end
      return !(temp >= TEMP_LOW && temp <= TEMP_HIGH);
   endfunction

   function automatic void queue_event(input kind_type kind, input logic [7:0] value,
                                       input logic last);
      result_type ev;
      ev       = '0;
      ev.kind  = kind;
      ev.value = value;
      ev.last  = last;
      pending_events.push_back(ev);
   endfunction

   function automatic void judge_frame();
      logic [7:0] md, t1, s1, f1, o1, t2, s2, f2, o2, vol, pre, snd;
      logic       loop_flag;
      result_type ev;
      md  = rx_store[SLOT_MODE];
      t1  = rx_store[SLOT_UNIT1 + OFS_TEMP];
      s1  = rx_store[SLOT_UNIT1 + OFS_SUST];
      f1  = rx_store[SLOT_UNIT1 + OFS_FAN];
      o1  = rx_store[SLOT_UNIT1 + OFS_FAN_ONLY];
      t2  = rx_store[SLOT_UNIT2 + OFS_TEMP];
      s2  = rx_store[SLOT_UNIT2 + OFS_SUST];
      f2  = rx_store[SLOT_UNIT2 + OFS_FAN];
      o2  = rx_store[SLOT_UNIT2 + OFS_FAN_ONLY];
      vol = rx_store[SLOT_VOL];
      pre = rx_store[SLOT_PRE];
      snd = rx_store[SLOT_SND];
      loop_flag = (rx_store[SLOT_LOOP] == FLAG_ON);
      if (rx_store[SLOT_ID] != own_id_model) begin
         queue_event(KIND_DROP, DROP_ID, 1'b1);
      end else if (md > MODE_MAX) begin
         queue_event(KIND_DROP, DROP_MODE, 1'b1);
      end else if (heater_rejected(t1, f1, o1)) begin
         queue_event(KIND_DROP, DROP_TEMP1, 1'b1);
      end else if (heater_rejected(t2, f2, o2)) begin
         queue_event(KIND_DROP, DROP_TEMP2, 1'b1);
      end else if (s1 > SUSTAIN_MAX) begin
         queue_event(KIND_DROP, DROP_SUST1, 1'b1);
      end else if (s2 > SUSTAIN_MAX) begin
         queue_event(KIND_DROP, DROP_SUST2, 1'b1);
      end else if (md == MODE_AUDIO && pre == 8'd0 && {t1, s1, f1, t2, s2, f2} == '0) begin
         if (vol != 8'd0) begin
            queue_event(KIND_AUDIO, VOLUME_MARK, 1'b0);
            queue_event(KIND_AUDIO, vol, 1'b1);
         end else if (snd == 8'd0) begin
            queue_event(KIND_AUDIO, AUDIO_STOP, 1'b1);
         end else begin
            queue_event(KIND_AUDIO, 8'(snd * 8'd2 - 8'd1 + 8'(loop_flag)), 1'b1);
         end
      end else begin
         ev          = '0;
         ev.kind     = KIND_COMMAND;
         ev.last     = 1'b1;
         ev.mode     = md[1:0];
         ev.unit_one = {o1 == FLAG_ON, f1, s1, t1};
         ev.unit_two = {o2 == FLAG_ON, f2, s2, t2};
         ev.loop_on  = loop_flag;
         ev.preset   = pre;
         ev.sound    = snd;
         pending_events.push_back(ev);
      end
   endfunction

   function automatic void predict_rx_byte(input logic [7:0] b);
      if (frame_pos == POS_HUNT) begin
         if (b == START_BYTE) begin
            frame_pos = POS_W'(1);
         end
      end else if (frame_pos != POS_LAST) begin
         rx_store[frame_pos - POS_W'(1)] = b;
         frame_pos = frame_pos + POS_W'(1);
      end else begin
         frame_pos = POS_HUNT;
         if (b != END_BYTE) begin
            queue_event(KIND_DROP, DROP_END, 1'b1);
         end else begin
            judge_frame();
         end
      end
   endfunction

   // --- result checking ---

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction kind %0d value %0h",
                                      rsp_event_kind, rsp_event_value));
         end else begin
            want = pending_events.pop_front();
            results_seen++;
            case (want.kind)
               KIND_COMMAND: commands_seen++;
               KIND_AUDIO:   audio_seen++;
               default:      drops_seen++;
            endcase
            compare_field("event_kind", 32'(rsp_event_kind), 32'(want.kind));
            compare_field("event_value", 32'(rsp_event_value), 32'(want.value));
            compare_field("last_of_run", 32'(rsp_last_of_run), 32'(want.last));
            compare_field("mode", 32'(rsp_mode), 32'(want.mode));
            compare_field("unit_one", 32'(rsp_unit_one), 32'(want.unit_one));
            compare_field("unit_two", 32'(rsp_unit_two), 32'(want.unit_two));
            compare_field("loop_on", 32'(rsp_loop_on), 32'(want.loop_on));
            compare_field("preset_number", 32'(rsp_preset_number), 32'(want.preset));
            compare_field("sound_track", 32'(rsp_sound_track), 32'(want.sound));
         end
      end
   end

   // --- driving ---

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_rx_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(input frame_image_type f);
      for (int i = 0; i < FRAME_BYTES; i++) begin
         send_byte(f[i]);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_own_id(input logic [7:0] id);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= id;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      own_id_model = id;
   endtask

   // --- frame builders ---

   function automatic frame_image_type nominal_frame();
      frame_image_type f;
      f                       = '0;
      f[0]                    = START_BYTE;
      f[AT_ID]                = own_id_model;
      f[AT_MODE]              = 8'd1;
      f[AT_UNIT1 + OFS_TEMP]  = 8'd25;
      f[AT_UNIT1 + OFS_SUST]  = 8'd30;
      f[AT_UNIT1 + OFS_FAN]   = 8'd100;
      f[AT_UNIT2 + OFS_TEMP]  = 8'd40;
      f[AT_UNIT2 + OFS_SUST]  = 8'd20;
      f[AT_UNIT2 + OFS_FAN]   = 8'd50;
      f[AT_VOL]               = 8'd7;
      f[AT_LOOP]              = FLAG_ON;
      f[AT_PRE]               = 8'd3;
      f[AT_SND]               = 8'd9;
      f[AT_END]               = END_BYTE;
      return f;
   endfunction

   function automatic frame_image_type audio_frame(input logic [7:0] vol, input logic [7:0] snd,
                                                   input logic [7:0] loop_byte);
      frame_image_type f;
      f = nominal_frame();
      f[AT_MODE] = MODE_AUDIO;
      f[AT_PRE]  = 8'd0;
      for (int i = 0; i < 3; i++) begin
         f[AT_UNIT1 + i] = 8'd0;
         f[AT_UNIT2 + i] = 8'd0;
      end
      f[AT_VOL]  = vol;
      f[AT_SND]  = snd;
      f[AT_LOOP] = loop_byte;
      return f;
   endfunction

   function automatic logic [7:0] pick_temp();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return $urandom_range(0, 1) ? TEMP_LOW - 8'd1 : TEMP_HIGH + 8'd1;
         2:       return 8'($urandom);
         default: return 8'($urandom_range(10, 60));
      endcase
   endfunction

   function automatic logic [7:0] pick_flag();
      case ($urandom_range(0, 3))
         0:       return FLAG_ON;
         1:       return 8'd0;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_frame();
      frame_image_type f;
      int              noise;
      int              base;
      noise = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
      repeat (noise) send_byte(8'($urandom_range(0, 254)));
      f[0]       = START_BYTE;
      f[AT_ID]   = ($urandom_range(0, 19) == 0) ? 8'($urandom) : own_id_model;
      f[AT_MODE] = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
      for (int u = 0; u < 2; u++) begin
         base = (u == 0) ? AT_UNIT1 : AT_UNIT2;
         f[base + OFS_TEMP]     = pick_temp();
         f[base + OFS_SUST]     = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                              : 8'($urandom_range(0, 60));
         f[base + OFS_FAN]      = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
         f[base + OFS_FAN_ONLY] = pick_flag();
      end
      f[AT_VOL]  = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
      f[AT_LOOP] = pick_flag();
      f[AT_PRE]  = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
      f[AT_SND]  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
      f[AT_END]  = ($urandom_range(0, 15) == 0) ? 8'($urandom) : END_BYTE;
      // audio-only content
      if ($urandom_range(0, 3) == 0) begin
         f[AT_MODE] = MODE_AUDIO;
         f[AT_PRE]  = 8'd0;
         for (int i = 0; i < 3; i++) begin
            f[AT_UNIT1 + i] = 8'd0;
            f[AT_UNIT2 + i] = 8'd0;
         end
      end
      send_frame(f);
   endtask

   // --- tests ---

   task automatic test_hunting_noise();
      send_byte(8'h00);
      send_byte(END_BYTE);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(8'h01);
      repeat (10) send_byte(8'($urandom_range(0, 254)));
   endtask

   task automatic test_frame_checks();
      frame_image_type f;
      send_frame(nominal_frame());
      // passing command with every field at its limit
      f = nominal_frame();
      f[AT_MODE] = MODE_MAX;
      f[AT_UNIT1 + OFS_TEMP] = TEMP_HIGH;
      f[AT_UNIT1 + OFS_SUST] = SUSTAIN_MAX;
      f[AT_UNIT1 + OFS_FAN]  = 8'hFF;
      f[AT_UNIT1 + OFS_FAN_ONLY] = 8'hFF;
      f[AT_UNIT2 + OFS_TEMP] = 8'hFF;
      f[AT_UNIT2 + OFS_SUST] = SUSTAIN_MAX;
      f[AT_UNIT2 + OFS_FAN]  = 8'd1;
      f[AT_UNIT2 + OFS_FAN_ONLY] = FLAG_ON;
      f[AT_VOL] = 8'hFF;
      f[AT_LOOP] = 8'hFF;
      f[AT_PRE] = 8'hFF;
      f[AT_SND] = START_BYTE;
      send_frame(f);
      // all zero command, temp 10 at the low edge
      f = '0;
      f[0] = START_BYTE;
      f[AT_ID] = own_id_model;
      f[AT_UNIT1 + OFS_TEMP] = TEMP_LOW;
      f[AT_UNIT1 + OFS_FAN]  = 8'd1;
      f[AT_END] = END_BYTE;
      send_frame(f);
      f = nominal_frame();
      f[AT_END] = 8'h00;
      send_frame(f);
      // start byte as the end byte, not a resync
      f[AT_END] = START_BYTE;
      send_frame(f);
      f = nominal_frame();
      f[AT_ID] = own_id_model + 8'd1;
      f[AT_MODE] = 8'd3;
      send_frame(f);
      f = nominal_frame();
      f[AT_MODE] = 8'd3;
      send_frame(f);
      f[AT_MODE] = 8'hFF;
      send_frame(f);
      f = nominal_frame();
      f[AT_UNIT1 + OFS_TEMP] = TEMP_LOW - 8'd1;
      f[AT_UNIT1 + OFS_SUST] = 8'hFF;
      send_frame(f);
      f = nominal_frame();
      f[AT_UNIT1 + OFS_TEMP] = TEMP_HIGH + 8'd1;
      send_frame(f);
      f = nominal_frame();
      f[AT_UNIT2 + OFS_TEMP] = 8'd1;
      send_frame(f);
      // out of range temps excused by fan off or fan only
      f = nominal_frame();
      f[AT_UNIT1 + OFS_TEMP] = 8'd5;
      f[AT_UNIT1 + OFS_FAN]  = 8'd0;
      f[AT_UNIT2 + OFS_TEMP] = 8'd200;
      f[AT_UNIT2 + OFS_FAN_ONLY] = FLAG_ON;
      send_frame(f);
      f = nominal_frame();
      f[AT_UNIT1 + OFS_SUST] = SUSTAIN_MAX + 8'd1;
      send_frame(f);
      f = nominal_frame();
      f[AT_UNIT2 + OFS_SUST] = 8'hFF;
      send_frame(f);
      send_frame(audio_frame(8'hFF, 8'd0, 8'd0));
      send_frame(audio_frame(8'd1, 8'd5, FLAG_ON));
      send_frame(audio_frame(8'd0, 8'd0, FLAG_ON));
      send_frame(audio_frame(8'd0, 8'd1, 8'd0));
      send_frame(audio_frame(8'd0, 8'hFF, FLAG_ON));
      send_frame(audio_frame(8'd0, 8'd128, FLAG_ON));
      send_frame(audio_frame(8'd0, 8'd20, 8'd2));
      // fan only flags do not spoil audio-only frames
      f = audio_frame(8'd0, 8'd3, FLAG_ON);
      f[AT_UNIT1 + OFS_FAN_ONLY] = FLAG_ON;
      f[AT_UNIT2 + OFS_FAN_ONLY] = 8'hFF;
      send_frame(f);
      f = audio_frame(8'd9, 8'd3, 8'd0);
      f[AT_UNIT2 + OFS_SUST] = 8'd1;
      send_frame(f);
   endtask

   task automatic test_own_id_register();
      frame_image_type f;
      write_own_id(8'h00);
      f = nominal_frame();
      send_frame(f);
      f[AT_ID] = 8'h01;
      send_frame(f);
      write_own_id(8'hFF);
      f = nominal_frame();
      send_frame(f);
      f[AT_ID] = 8'hFE;
      send_frame(f);
      write_own_id(8'h5A);
      send_frame(audio_frame(8'd0, 8'd77, 8'd0));
   endtask

   task automatic test_random_traffic();
      int idle_pct  [4] = '{0, 48, 0, 19};
      int stall_pct [4] = '{0, 0, 48, 19};
      logic [7:0] phase_id;
      for (int ph = 0; ph < 4; ph++) begin
         phase_id = (ph == 1) ? 8'h00 : (ph == 2) ? 8'hFF : 8'($urandom);
         write_own_id(phase_id);
         sender_idle_pct    = idle_pct[ph];
         receiver_stall_pct = stall_pct[ph];
         repeat (FRAMES_PER_PHASE) send_random_frame();
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      rsp_ready   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 8'h00;
      frame_pos    = POS_HUNT;
      own_id_model = OWN_ID_RESET;
      foreach (rx_store[i]) rx_store[i] = 8'h00;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_hunting_noise();
      test_frame_checks();
      test_own_id_register();
      test_random_traffic();
      wait_idle();
      repeat (20) @(posedge clock);
      $display("sent %0d bytes over four traffic phases and several own id settings",
               bytes_sent);
      $display("checked %0d results: %0d commands, %0d audio bytes, %0d drops, %0d errors",
               results_seen, commands_seen, audio_seen, drops_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASS framed_command_packet_receiver");
      end else begin
         $display("FAIL framed_command_packet_receiver");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", pending_events.size());
      $display("FAIL framed_command_packet_receiver");
      $finish;
   end

endmodule
